// File: rtl/core/hesd_pkg.sv
// Constants, types and CORDIC helper functions for the heading error steering decision unit.
`timescale 1ns / 1ps

package hesd_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COMP_W        = 16;
  localparam int XY_W          = COMP_W + 4;
  localparam int Z_W           = 25;
  localparam int D_W           = Z_W + 1;
  localparam int RND_SHIFT     = 8;
  localparam int H_W           = D_W - RND_SHIFT;
  localparam int T_W           = H_W + 1;
  localparam int HE_W          = 16;
  localparam int TOL_W         = 15;
  localparam int LAT           = CORDIC_STAGES + 4;
  localparam int IN_DATA_W     = 4 * COMP_W;
  localparam int OUT_DATA_W    = 24;
  localparam int CMD_W         = 2;

  localparam logic [TOL_W-1:0]     TOL_RESET      = TOL_W'(128);
  localparam logic signed [Z_W-1:0] HALF_TURN_FINE = Z_W'(5898240);
  localparam logic signed [D_W-1:0] RND_BIAS       = D_W'(128);
  localparam logic signed [T_W-1:0] HALF_TURN      = T_W'(23040);
  localparam logic signed [T_W-1:0] FULL_TURN      = T_W'(46080);

  typedef enum logic [CMD_W-1:0] {
    CMD_REACHED = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  // Arctangent of 2^-i in units of 2^-15 degree.
  function automatic logic signed [Z_W-1:0] atan_fine(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = Z_W'(1474560);
      1:       a = Z_W'(870484);
      2:       a = Z_W'(459940);
      3:       a = Z_W'(233473);
      4:       a = Z_W'(117189);
      5:       a = Z_W'(58652);
      6:       a = Z_W'(29333);
      7:       a = Z_W'(14667);
      8:       a = Z_W'(7334);
      9:       a = Z_W'(3667);
      10:      a = Z_W'(1833);
      11:      a = Z_W'(917);
      12:      a = Z_W'(458);
      13:      a = Z_W'(229);
      14:      a = Z_W'(115);
      15:      a = Z_W'(57);
      16:      a = Z_W'(29);
      17:      a = Z_W'(14);
      18:      a = Z_W'(7);
      19:      a = Z_W'(4);
      20:      a = Z_W'(2);
      21:      a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Total angle that a zero vector accumulates, all stages turning positively.
  function automatic logic signed [Z_W-1:0] atan_sum(input int n);
    logic signed [Z_W-1:0] s;
    s = '0;
    for (int k = 0; k < n; k++) begin
      s = s + atan_fine(k);
    end
    return s;
  endfunction

  // Turns a left half-plane vector by 180 degrees; a zero vector starts at
  // minus the full stage sum so that it ends at zero.
  function automatic vec_t prerotate(input logic signed [COMP_W-1:0] x,
                                     input logic signed [COMP_W-1:0] y);
    vec_t v;
    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;
    xe = XY_W'(x);
    ye = XY_W'(y);
    if (x == '0 && y == '0) begin
      v.x = '0;
      v.y = '0;
      v.z = -atan_sum(CORDIC_STAGES);
    end else if (x < 0) begin
      v.x = -xe;
      v.y = -ye;
      v.z = (y >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
    end else begin
      v.x = xe;
      v.y = ye;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic vec_t cordic_step(input vec_t v, input int i);
    vec_t r;
    if (!v.y[XY_W-1]) begin
      r.x = v.x + (v.y >>> i);
      r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_fine(i);
    end else begin
      r.x = v.x - (v.y >>> i);
      r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_fine(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/heading_error_steer_decision_unit.sv
// Top level of the heading error steering decision unit: pipelined CORDIC atan2 and decision.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one sample per transfer: a compass vector and a
// target direction vector, four signed 16-bit components. The output stream
// returns one transfer per sample with the steering command and the wrapped
// heading error in units of 1/128 degree.
// The tolerance register is written through cfg_wr_en and cfg_wr_data while
// no sample is in flight; reset sets it to 128 (one degree).
// From an input transfer to the output transfer of its result, a sample passes
// one pre-rotation stage, one stage per CORDIC iteration (16), a rounding
// stage, a wrap stage and the output register. Both vectors run through their
// own CORDIC stages side by side, so a new sample is taken in every cycle
// unless the receiver stalls.
// When the receiver stalls, the whole pipeline holds and in_tready drops;
// nothing is lost or repeated, and the pending result stays on out_tdata.
// Reset clears all valid bits, so the output channel is empty afterwards.
module heading_error_steer_decision_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // compass_x, compass_y, dest_x, dest_y
  input  logic [hesd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cmd, heading_error, zero fill
  output logic [hesd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [hesd_pkg::TOL_W-1:0]         cfg_wr_data
);

  localparam int NS = hesd_pkg::CORDIC_STAGES;

  logic                              en;
  logic [hesd_pkg::LAT-1:0]          vld_r;
  logic [hesd_pkg::TOL_W-1:0]        tol_r;

  hesd_pkg::vec_t                    cmp_r [NS+1];
  hesd_pkg::vec_t                    dst_r [NS+1];
  hesd_pkg::vec_t                    cmp_nxt [NS+1];
  hesd_pkg::vec_t                    dst_nxt [NS+1];

  logic signed [hesd_pkg::D_W-1:0]   diff_sum;
  logic signed [hesd_pkg::H_W-1:0]   h_r;
  logic signed [hesd_pkg::H_W-1:0]   h_nxt;
  logic signed [hesd_pkg::T_W-1:0]   t_sum;
  logic signed [hesd_pkg::T_W-1:0]   t_wrap;
  logic signed [hesd_pkg::HE_W-1:0]  he_r;
  logic signed [hesd_pkg::HE_W-1:0]  he_nxt;
  logic [hesd_pkg::HE_W-1:0]         mag;
  hesd_pkg::cmd_t                    cmd_r;
  hesd_pkg::cmd_t                    cmd_nxt;
  logic signed [hesd_pkg::HE_W-1:0]  herr_r;

  assign en        = !vld_r[hesd_pkg::LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= hesd_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[hesd_pkg::LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    cmp_nxt[0] = hesd_pkg::prerotate(in_tdata[hesd_pkg::COMP_W-1:0],
                                     in_tdata[2*hesd_pkg::COMP_W-1:hesd_pkg::COMP_W]);
    dst_nxt[0] = hesd_pkg::prerotate(in_tdata[3*hesd_pkg::COMP_W-1:2*hesd_pkg::COMP_W],
                                     in_tdata[4*hesd_pkg::COMP_W-1:3*hesd_pkg::COMP_W]);
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_comb begin
      cmp_nxt[i+1] = hesd_pkg::cordic_step(cmp_r[i], i);
      dst_nxt[i+1] = hesd_pkg::cordic_step(dst_r[i], i);
    end
  end

  for (genvar i = 0; i <= NS; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        cmp_r[i] <= cmp_nxt[i];
        dst_r[i] <= dst_nxt[i];
      end
    end
  end

  always_comb begin
    diff_sum = hesd_pkg::D_W'(dst_r[NS].z) - hesd_pkg::D_W'(cmp_r[NS].z)
             + hesd_pkg::RND_BIAS;
    h_nxt    = diff_sum[hesd_pkg::D_W-1:hesd_pkg::RND_SHIFT];
  end

  always_comb begin
    t_sum = hesd_pkg::T_W'(h_r) + hesd_pkg::HALF_TURN;
    if (t_sum >= hesd_pkg::FULL_TURN) begin
      t_wrap = t_sum - hesd_pkg::FULL_TURN;
    end else if (t_sum < 0) begin
      t_wrap = t_sum + hesd_pkg::FULL_TURN;
    end else begin
      t_wrap = t_sum;
    end
    he_nxt = hesd_pkg::HE_W'(t_wrap - hesd_pkg::HALF_TURN);
  end

  always_comb begin
    mag = he_r[hesd_pkg::HE_W-1] ? hesd_pkg::HE_W'(-he_r) : hesd_pkg::HE_W'(he_r);
    if (mag < hesd_pkg::HE_W'(tol_r)) begin
      cmd_nxt = hesd_pkg::CMD_REACHED;
    end else if (he_r > 0) begin
      cmd_nxt = hesd_pkg::CMD_LEFT;
    end else begin
      cmd_nxt = hesd_pkg::CMD_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_nxt;
      he_r   <= he_nxt;
      cmd_r  <= cmd_nxt;
      herr_r <= he_r;
    end
  end

  assign out_tvalid = vld_r[hesd_pkg::LAT-1];
  assign out_tdata  = {{(hesd_pkg::OUT_DATA_W - hesd_pkg::HE_W - hesd_pkg::CMD_W){1'b0}},
                       herr_r, cmd_r};

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (herr_r >= -16'sd23040 && herr_r <= 16'sd23039))
    else $error("heading error outside the wrapped range");

  a_cmd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((cmd_r != hesd_pkg::CMD_LEFT || herr_r > 0) &&
                    (cmd_r != hesd_pkg::CMD_RIGHT || herr_r <= 0)))
    else $error("steering command disagrees with the error sign");

  a_reached_tol: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[hesd_pkg::LAT-2] && en && $stable(tol_r)) |=>
      (cmd_r != hesd_pkg::CMD_REACHED ||
       herr_r < $signed({1'b0, tol_r}) && herr_r > -$signed({1'b0, tol_r})))
    else $error("reached reported with the error beyond the tolerance");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(herr_r) && $stable(h_r))
    else $error("pipeline moved during a stall");

endmodule

// File: sim/heading_error_steer_decision_checker.sv
// Checker for the heading error steering unit: predicts each result and compares the output stream.
`timescale 1ns / 1ps

module heading_error_steer_decision_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // compass_x, compass_y, dest_x, dest_y
  input  logic [hesd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // cmd, heading_error, zero fill
  input  logic [hesd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [hesd_pkg::TOL_W-1:0]      cfg_wr_data,
  output int                              mismatches,
  output int                              outstanding
);

  localparam longint HALF_TURN_UNITS = 5898240;
  localparam int     ANGLE_STEPS     = (hesd_pkg::CORDIC_STAGES < 24) ?
                                       hesd_pkg::CORDIC_STAGES : 24;

  typedef struct packed {
    hesd_pkg::cmd_t                   cmd;
    logic signed [hesd_pkg::HE_W-1:0] heading;
  } steer_result_t;

  steer_result_t              expected_q[$];
  steer_result_t              due;
  logic [hesd_pkg::TOL_W-1:0] tolerance = hesd_pkg::TOL_RESET;
  int                         mismatch_count = 0;
  int                         pending_count = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = pending_count;

  function automatic longint arctan_units(input int i);
    case (i)
      0:       return 1474560;
      1:       return 870484;
      2:       return 459940;
      3:       return 233473;
      4:       return 117189;
      5:       return 58652;
      6:       return 29333;
      7:       return 14667;
      8:       return 7334;
      9:       return 3667;
      10:      return 1833;
      11:      return 917;
      12:      return 458;
      13:      return 229;
      14:      return 115;
      15:      return 57;
      16:      return 29;
      17:      return 14;
      18:      return 7;
      19:      return 4;
      20:      return 2;
      21:      return 1;
      default: return 0;
    endcase
  endfunction

  // Angle of (xi, yi) in units of 2^-15 degree.
  function automatic longint vector_angle(input logic signed [hesd_pkg::COMP_W-1:0] xi,
                                          input logic signed [hesd_pkg::COMP_W-1:0] yi);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_UNITS : -HALF_TURN_UNITS;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_units(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_units(i);
      end
    end
    return z;
  endfunction

  function automatic steer_result_t predict_steer(input logic [hesd_pkg::IN_DATA_W-1:0] d,
                                                  input logic [hesd_pkg::TOL_W-1:0] tol);
    steer_result_t r;
    longint diff;
    longint h;
    longint mag;
    diff = vector_angle(d[47:32], d[63:48]) - vector_angle(d[15:0], d[31:16]);
    h = (diff + 128) >>> 8;
    h = (h + 23040) % 46080;
    if (h < 0) h = h + 46080;
    h = h - 23040;
    mag = (h < 0) ? -h : h;
    if (mag < longint'(tol)) r.cmd = hesd_pkg::CMD_REACHED;
    else if (h > 0) r.cmd = hesd_pkg::CMD_LEFT;
    else r.cmd = hesd_pkg::CMD_RIGHT;
    r.heading = h[hesd_pkg::HE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tolerance <= hesd_pkg::TOL_RESET;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      if (cfg_wr_en) tolerance <= cfg_wr_data;
      if (in_tvalid && in_tready) expected_q.push_back(predict_steer(in_tdata, tolerance));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result transfer 0x%06h with no sample waiting",
                                    out_tdata));
        end else begin
          due = expected_q.pop_front();
          if (out_tdata[1:0] !== due.cmd)
            report_mismatch($sformatf("cmd %0d, expected %0d", out_tdata[1:0], due.cmd));
          if (out_tdata[17:2] !== due.heading)
            report_mismatch($sformatf("heading_error %0d, expected %0d",
                                      $signed(out_tdata[17:2]), due.heading));
        end
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

// File: sim/heading_error_steer_decision_unit_tb.sv
// Testbench top for the heading error steering unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module heading_error_steer_decision_unit_tb;

  localparam int CYCLE_LIMIT = 100000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hesd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hesd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [hesd_pkg::TOL_W-1:0]      cfg_wr_data = '0;
  int                              mismatches;
  int                              outstanding;
  int                              in_idle_pct = 10;
  int                              out_idle_pct = 10;
  int                              samples_sent = 0;
  int                              cycles = 0;

  always #5 clk = ~clk;

  heading_error_steer_decision_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  heading_error_steer_decision_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [hesd_pkg::IN_DATA_W-1:0] pack(input int cx, input int cy,
                                                          input int dx, input int dy);
    return {dy[15:0], dx[15:0], cy[15:0], cx[15:0]};
  endfunction

  function automatic logic [hesd_pkg::COMP_W-1:0] rand_component();
    logic [31:0] r;
    r = $urandom;
    return r[hesd_pkg::COMP_W-1:0];
  endfunction

  function automatic logic [hesd_pkg::COMP_W-1:0] corner_value();
    logic [hesd_pkg::COMP_W-1:0] v;
    case ($urandom_range(5))
      0:       v = 16'h8000;
      1:       v = 16'hFFFF;
      2:       v = 16'h0000;
      3:       v = 16'h0001;
      4:       v = 16'h7FFF;
      default: v = rand_component();
    endcase
    return v;
  endfunction

  function automatic logic [hesd_pkg::COMP_W-1:0] small_value();
    int t;
    t = int'($urandom_range(16)) - 8;
    return t[15:0];
  endfunction

  function automatic logic [hesd_pkg::COMP_W-1:0] nudge(
      input logic signed [hesd_pkg::COMP_W-1:0] v, input int span);
    int t;
    t = int'(v) + int'($urandom_range(2 * span)) - span;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic logic [hesd_pkg::IN_DATA_W-1:0] random_sample();
    logic signed [hesd_pkg::COMP_W-1:0] cx;
    logic signed [hesd_pkg::COMP_W-1:0] cy;
    logic signed [hesd_pkg::COMP_W-1:0] dx;
    logic signed [hesd_pkg::COMP_W-1:0] dy;
    int span;
    cx = rand_component();
    cy = rand_component();
    dx = rand_component();
    dy = rand_component();
    span = $urandom_range(600);
    if ($urandom_range(1)) begin
      cx = cx >>> $urandom_range(12);
      cy = cy >>> $urandom_range(12);
    end
    case ($urandom_range(9))
      0, 1, 2: begin
        cx = rand_component();
        cy = rand_component();
      end
      3: begin
        cx = corner_value();
        cy = corner_value();
        dx = corner_value();
        dy = corner_value();
      end
      4, 5, 6: begin
        dx = nudge(cx, span);
        dy = nudge(cy, span);
      end
      7: begin
        cx = small_value();
        cy = small_value();
        dx = small_value();
        dy = small_value();
      end
      8: begin
        dx = nudge(-cx, span);
        dy = nudge(-cy, span);
      end
      default: begin
        dx = nudge(-cy, span);
        dy = nudge(cx, span);
      end
    endcase
    return {dy, dx, cy, cx};
  endfunction

  task automatic send(input logic [hesd_pkg::IN_DATA_W-1:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send(random_sample());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [hesd_pkg::TOL_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(pack(0, 0, 0, 0));
    send(pack(0, 0, 1000, 0));
    send(pack(0, 0, 0, 1000));
    send(pack(1000, 0, 0, 0));
    send(pack(1000, 0, -32768, 0));
    send(pack(-1, 0, 1, 0));
    send(pack(32767, 32767, -32768, -32768));
    send(pack(-32768, -32768, 32767, 32767));
    send(pack(32767, -32768, -32768, 32767));
    send(pack(-32768, 32767, 32767, -32768));
    send(pack(12345, -2222, 12345, -2222));
    send(pack(1000, 0, 0, 1000));
    send(pack(0, 1000, 1000, 0));
    send(pack(10000, 0, 10000, 175));
    send(pack(10000, 0, 10000, -175));
    send(pack(10000, 0, 10000, 170));
    send(pack(0, -32768, 0, 32767));
    send(pack(-5, -5, 5, 5));
    send(pack(1, 1, -1, -1));
    send(pack(32767, 0, 32767, 1));
    send(pack(-32768, -1, -32768, 0));
    run_random(400);

    write_tolerance(hesd_pkg::TOL_W'(0));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(300);
    in_idle_pct  = 10;
    out_idle_pct = 10;

    write_tolerance(hesd_pkg::TOL_W'(23040));
    run_random(200);
    write_tolerance(hesd_pkg::TOL_W'(32767));
    run_random(150);
    write_tolerance(hesd_pkg::TOL_W'($urandom_range(23040)));
    run_random(350);
    write_tolerance(hesd_pkg::TOL_W'(1));
    run_random(200);
    write_tolerance(hesd_pkg::TOL_RESET);
    run_random(200);

    drain();
    repeat (hesd_pkg::LAT + 8) @(posedge clk);

    $display("Sent %0d samples under the reset tolerance and six written settings,", samples_sent);
    $display("including 0, 1, 23040 and 32767, with %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
